// ===== hdl/differential_phase_correlator_defines.svh =====
// Assertion helpers for the correlator top module.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef DIFFERENTIAL_PHASE_CORRELATOR_DEFINES_SVH
`define DIFFERENTIAL_PHASE_CORRELATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dpc_pkg.sv =====
package dpc_pkg;

    localparam int TAPS_DEF        = 32;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int PHASE_W         = 8;
    localparam int UNIT_W          = 16;
    localparam int MAG_W           = 20;
    localparam int MAG_LIMIT       = 524288;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int TAP_CNT_W       = 6;
    localparam int BND_IDX_W       = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_REF_WORD_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_WORD_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_WORD_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REF_WORD_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUANT,
        ST_SUM,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_ROOT,
        ST_OUT
    } dpc_state_t;

    typedef enum logic [1:0] {
        Q_IDLE,
        Q_PROBE,
        Q_CMP,
        Q_DONE
    } quant_state_t;

    // One delay-line entry as it moves from cell to cell.
    typedef struct packed {
        logic               vld;
        logic [PHASE_W-1:0] diff;
    } link_t;

    // sin(k * 2pi / 256) * 16384, k = 0..64.
    localparam logic [UNIT_W-1:0] QSINE [0:64] = '{
        16'd0,     16'd402,   16'd804,   16'd1205,  16'd1606,  16'd2006,  16'd2404,  16'd2801,
        16'd3196,  16'd3590,  16'd3981,  16'd4370,  16'd4756,  16'd5139,  16'd5520,  16'd5897,
        16'd6270,  16'd6639,  16'd7005,  16'd7366,  16'd7723,  16'd8076,  16'd8423,  16'd8765,
        16'd9102,  16'd9434,  16'd9760,  16'd10080, 16'd10394, 16'd10702, 16'd11003, 16'd11297,
        16'd11585, 16'd11866, 16'd12140, 16'd12406, 16'd12665, 16'd12916, 16'd13160, 16'd13395,
        16'd13623, 16'd13842, 16'd14053, 16'd14256, 16'd14449, 16'd14635, 16'd14811, 16'd14978,
        16'd15137, 16'd15286, 16'd15426, 16'd15557, 16'd15679, 16'd15791, 16'd15893, 16'd15986,
        16'd16069, 16'd16143, 16'd16207, 16'd16261, 16'd16305, 16'd16340, 16'd16364, 16'd16379,
        16'd16384
    };

    function automatic logic signed [UNIT_W-1:0] sine_of(input logic [PHASE_W-1:0] k);
        logic [6:0] r;
        logic [6:0] rr;
        logic signed [UNIT_W-1:0] v;
        r  = {1'b0, k[5:0]};
        rr = 7'd64 - r;
        case (k[7:6])
            2'd0:    v = signed'(QSINE[r]);
            2'd1:    v = signed'(QSINE[rr]);
            2'd2:    v = -signed'(QSINE[r]);
            2'd3:    v = -signed'(QSINE[rr]);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Octant boundary j lies between steps j and j+1: cosine and sine sums.
    function automatic logic [UNIT_W-1:0] bnd_cos(input logic [4:0] j);
        logic [6:0] a;
        a = 7'd64 - {2'b00, j};
        return QSINE[a] + QSINE[a - 7'd1];
    endfunction

    function automatic logic [UNIT_W-1:0] bnd_sin(input logic [4:0] j);
        logic [6:0] a;
        a = {2'b00, j};
        return QSINE[a] + QSINE[a + 7'd1];
    endfunction

endpackage

// ===== hdl/dpc_phase_quant.sv =====
module dpc_phase_quant #(
    parameter int SAMPLE_BITS = dpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [SAMPLE_BITS-1:0]    sample_i,
    input  logic signed [SAMPLE_BITS-1:0]    sample_q,
    output logic                             done,
    output logic [dpc_pkg::PHASE_W-1:0]      phase
);

    localparam int PROD_W = SAMPLE_BITS + dpc_pkg::UNIT_W;
    localparam int BW     = dpc_pkg::BND_IDX_W;

    dpc_pkg::quant_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] x_reg, y_reg;
    logic                   swap_reg, neg_i_reg, neg_q_reg;
    logic [BW-1:0]          lo_reg, hi_reg;
    logic [PROD_W-1:0]      prod_reg;

    logic [SAMPLE_BITS-1:0] abs_i, abs_q;
    logic [BW:0]            mid_sum;
    logic [BW-1:0]          mid;
    logic [PROD_W-1:0]      prod_y, prod_x;
    logic [dpc_pkg::PHASE_W-1:0] a_oct, a_half;

    assign abs_i   = sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;
    assign abs_q   = sample_q[SAMPLE_BITS-1] ? (~sample_q + 1'b1) : sample_q;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[BW:1];
    assign prod_y  = PROD_W'(y_reg) * PROD_W'(dpc_pkg::bnd_cos(mid[4:0]));
    assign prod_x  = PROD_W'(x_reg) * PROD_W'(dpc_pkg::bnd_sin(mid[4:0]));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dpc_pkg::Q_IDLE:  if (start) state_next = dpc_pkg::Q_PROBE;
            dpc_pkg::Q_PROBE: state_next = (lo_reg == hi_reg) ? dpc_pkg::Q_DONE
                                                              : dpc_pkg::Q_CMP;
            dpc_pkg::Q_CMP:   state_next = dpc_pkg::Q_PROBE;
            dpc_pkg::Q_DONE:  state_next = dpc_pkg::Q_IDLE;
            default:          state_next = dpc_pkg::Q_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dpc_pkg::Q_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Boundary tests fail from some index on, so the step count is found by
    // bisection: state Q_PROBE registers y*c, and Q_CMP compares it against x*s.
    always_ff @(posedge aclk) begin
        case (state_reg)
            dpc_pkg::Q_IDLE: begin
                if (start) begin
                    swap_reg  <= abs_q > abs_i;
                    x_reg     <= (abs_q > abs_i) ? abs_q : abs_i;
                    y_reg     <= (abs_q > abs_i) ? abs_i : abs_q;
                    neg_i_reg <= sample_i[SAMPLE_BITS-1];
                    neg_q_reg <= sample_q[SAMPLE_BITS-1];
                    lo_reg    <= '0;
                    hi_reg    <= (abs_i == '0 && abs_q == '0) ? BW'(0) : BW'(32);
                end
            end
            dpc_pkg::Q_PROBE: begin
                prod_reg <= prod_y;
            end
            dpc_pkg::Q_CMP: begin
                if (prod_x <= prod_reg) begin
                    lo_reg <= mid + 1'b1;
                end else begin
                    hi_reg <= mid;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        done   = (state_reg == dpc_pkg::Q_DONE);
        a_oct  = swap_reg ? (8'd64 - 8'(lo_reg)) : 8'(lo_reg);
        a_half = neg_i_reg ? (8'd128 - a_oct) : a_oct;
        phase  = neg_q_reg ? (8'd0 - a_half) : a_half;
    end

endmodule

// ===== hdl/dpc_cell.sv =====
module dpc_cell #(
    parameter int SUM_W = 22
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_en,
    input  dpc_pkg::link_t                link_in,
    output dpc_pkg::link_t                link_out,
    input  logic [dpc_pkg::PHASE_W-1:0]   ref_phase,
    input  logic                          active,
    input  logic signed [SUM_W-1:0]       psum_re_in,
    input  logic signed [SUM_W-1:0]       psum_im_in,
    output logic signed [SUM_W-1:0]       psum_re_out,
    output logic signed [SUM_W-1:0]       psum_im_out
);

    logic                          vld_reg;
    logic [dpc_pkg::PHASE_W-1:0]   diff_reg;
    logic signed [SUM_W-1:0]       psum_re_reg, psum_im_reg;
    logic [dpc_pkg::PHASE_W-1:0]   ang;
    logic signed [dpc_pkg::UNIT_W-1:0] c_val, s_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (shift_en) begin
            vld_reg <= link_in.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            diff_reg <= link_in.diff;
        end
    end

    assign ang = diff_reg + ref_phase;

    always_comb begin
        if (vld_reg && active) begin
            c_val = dpc_pkg::sine_of(ang + 8'd64);
            s_val = dpc_pkg::sine_of(ang);
        end else begin
            c_val = '0;
            s_val = '0;
        end
    end

    // The partial sum ripples one cell per clock toward the end of the row.
    always_ff @(posedge aclk) begin
        psum_re_reg <= psum_re_in + SUM_W'(c_val);
        psum_im_reg <= psum_im_in + SUM_W'(s_val);
    end

    assign link_out.vld  = vld_reg;
    assign link_out.diff = diff_reg;
    assign psum_re_out   = psum_re_reg;
    assign psum_im_out   = psum_im_reg;

endmodule

// ===== hdl/dpc_sqrt.sv =====
module dpc_sqrt #(
    parameter int ROOT_W = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic                  done,
    output logic [ROOT_W-1:0]     root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic              busy_reg, done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0]  rem_sh, trial;
    logic              fits;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // One result bit per clock, two radicand bits brought down each time.
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/differential_phase_correlator.sv =====
// Differential phase correlator for preamble detection.
// Input beats on s_tvalid/s_tready carry one complex sample each. Every sample
// is reduced to an 8-bit phase, the step from the previous phase enters a row
// of TAPS cells, and each cell rotates its delayed step by the reference step
// for its tap. The rotated unit phasors are summed along the row and the
// floored magnitude of the sum leaves as one beat on m_tvalid/m_tready.
// Reference steps and the tap count are written on the cfg_* channel, which is
// always ready; write it only while no sample is in flight.
// From sample accept to result valid, a sample passes through the bisection
// probes of the phase quantizer, the partial-sum ripple through the cell row,
// the squaring of the real and imaginary parts and the bit-serial square
// root; ROOT_W is 20 for 32 taps. One sample is processed at a time, so the
// next input beat is accepted only once the sequencer is back in idle; the
// ripple and the square root take most of that time.
// Reset clears the delay line, the previous phase, the reference steps and
// sets the tap count to 32. When the receiver stalls, the finished result
// waits in the output register while the next sample is already accepted and
// processed; the block then holds its next result until the register frees.
`include "differential_phase_correlator_defines.svh"

module differential_phase_correlator #(
    parameter int TAPS        = dpc_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = dpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] sample_i, [31:16] sample_q
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [19:0] corr_magnitude, [23:20] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SUM_W  = 17 + $clog2(TAPS);
    localparam int ROOT_W = SUM_W - 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int CNT_W  = $clog2(TAPS);
    localparam int TW     = dpc_pkg::TAP_CNT_W;
    localparam int PW     = dpc_pkg::PHASE_W;

    dpc_pkg::dpc_state_t state_reg, state_next;

    logic [4*dpc_pkg::CFG_DATA_W-1:0] ref_bits_reg;
    logic [TW-1:0]                    taps_reg;
    logic [PW-1:0]                    prev_phase_reg;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [RAD_W-1:0]                 sq_reg;
    logic                             m_tvalid_reg;
    logic [dpc_pkg::MAG_W-1:0]        mag_reg;

    logic              s_accept, out_free, out_load;
    logic              q_start, q_done, shift_en, sq_start, sq_done;
    logic [PW-1:0]     q_phase;
    logic [TW-1:0]     n_eff;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W:0]   root_ext;
    logic [dpc_pkg::MAG_W:0] root_wide;
    logic [dpc_pkg::MAG_W-1:0] mag_next;

    logic signed [SUM_W-1:0]   mul_op;
    logic signed [2*SUM_W-1:0] prod;
    logic [RAD_W-1:0]          radicand;

    dpc_pkg::link_t          head;
    dpc_pkg::link_t          link_q  [TAPS];
    logic signed [SUM_W-1:0] psum_re [TAPS];
    logic signed [SUM_W-1:0] psum_im [TAPS];

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_bits_reg <= '0;
            taps_reg     <= TW'(32);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dpc_pkg::REG_REF_WORD_0:  ref_bits_reg[0   +: 64] <= cfg_data;
                dpc_pkg::REG_REF_WORD_1:  ref_bits_reg[64  +: 64] <= cfg_data;
                dpc_pkg::REG_REF_WORD_2:  ref_bits_reg[128 +: 64] <= cfg_data;
                dpc_pkg::REG_REF_WORD_3:  ref_bits_reg[192 +: 64] <= cfg_data;
                dpc_pkg::REG_TAPS_IN_USE: taps_reg <= cfg_data[TW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign n_eff = (taps_reg > TW'(TAPS)) ? TW'(TAPS) : taps_reg;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dpc_pkg::ST_IDLE:  if (s_accept) state_next = dpc_pkg::ST_QUANT;
            dpc_pkg::ST_QUANT: if (q_done) state_next = dpc_pkg::ST_SUM;
            dpc_pkg::ST_SUM:   if (cnt_reg == CNT_W'(TAPS - 1)) state_next = dpc_pkg::ST_SQ_RE;
            dpc_pkg::ST_SQ_RE: state_next = dpc_pkg::ST_SQ_IM;
            dpc_pkg::ST_SQ_IM: state_next = dpc_pkg::ST_ROOT;
            dpc_pkg::ST_ROOT: begin
                if (sq_done) begin
                    state_next = out_free ? dpc_pkg::ST_IDLE : dpc_pkg::ST_OUT;
                end
            end
            dpc_pkg::ST_OUT:   if (out_free) state_next = dpc_pkg::ST_IDLE;
            default:           state_next = dpc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == dpc_pkg::ST_IDLE);
        q_start  = (state_reg == dpc_pkg::ST_IDLE) && s_tvalid;
        shift_en = (state_reg == dpc_pkg::ST_QUANT) && q_done;
        sq_start = (state_reg == dpc_pkg::ST_SQ_IM);
        out_load = out_free && (((state_reg == dpc_pkg::ST_ROOT) && sq_done)
                                || (state_reg == dpc_pkg::ST_OUT));
        mul_op   = (state_reg == dpc_pkg::ST_SQ_IM) ? psum_im[TAPS-1] : psum_re[TAPS-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dpc_pkg::ST_IDLE;
            cnt_reg        <= '0;
            prev_phase_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_reg == dpc_pkg::ST_SUM) ? cnt_reg + 1'b1 : '0;
            if (shift_en) begin
                prev_phase_reg <= q_phase;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    dpc_phase_quant #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_quant (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (q_start),
        .sample_i (s_tdata[SAMPLE_BITS-1:0]),
        .sample_q (s_tdata[16 +: SAMPLE_BITS]),
        .done     (q_done),
        .phase    (q_phase)
    );

    assign head.vld  = 1'b1;
    assign head.diff = q_phase - prev_phase_reg;

    // Cell k holds the k-th most recent phase step and pairs it with
    // reference tap n-1-k.
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        logic [TW-1:0] ref_idx;
        logic [PW-1:0] ref_phase;

        assign ref_idx   = n_eff - TW'(1) - TW'(k);
        assign ref_phase = ref_bits_reg[{ref_idx[4:0], 3'b000} +: PW];

        dpc_cell #(
            .SUM_W(SUM_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (shift_en),
            .link_in     ((k == 0) ? head : link_q[(k == 0) ? 0 : k - 1]),
            .link_out    (link_q[k]),
            .ref_phase   (ref_phase),
            .active      (TW'(k) < n_eff),
            .psum_re_in  ((k == 0) ? SUM_W'(0) : psum_re[(k == 0) ? 0 : k - 1]),
            .psum_im_in  ((k == 0) ? SUM_W'(0) : psum_im[(k == 0) ? 0 : k - 1]),
            .psum_re_out (psum_re[k]),
            .psum_im_out (psum_im[k])
        );
    end

    // One shared multiplier squares the real part, then the imaginary part.
    assign prod     = mul_op * mul_op;
    assign radicand = sq_reg + prod[RAD_W-1:0];

    always_ff @(posedge aclk) begin
        if (state_reg == dpc_pkg::ST_SQ_RE) begin
            sq_reg <= prod[RAD_W-1:0];
        end
    end

    dpc_sqrt #(
        .ROOT_W(ROOT_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (radicand),
        .done     (sq_done),
        .root     (root)
    );

    assign root_ext  = {1'b0, root};
    assign root_wide = (dpc_pkg::MAG_W + 1)'(root_ext);
    assign mag_next  = (root_wide > (dpc_pkg::MAG_W + 1)'(dpc_pkg::MAG_LIMIT))
                     ? dpc_pkg::MAG_W'(dpc_pkg::MAG_LIMIT)
                     : root_wide[dpc_pkg::MAG_W-1:0];

    always_ff @(posedge aclk) begin
        if (out_load) begin
            mag_reg <= mag_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, mag_reg};

    `DPC_ASSERT_IMP(a_line_prefix, link_q[TAPS-1].vld, link_q[0].vld,
                    "delay line valid bits are not a filled prefix")
    `DPC_ASSERT_IMP(a_mag_limit, m_tvalid, m_tdata[19:0] <= 20'd524288,
                    "result magnitude above saturation limit")
    `DPC_ASSERT_IMP(a_root_done, sq_done, state_reg == dpc_pkg::ST_ROOT,
                    "square root finished outside its wait state")
    `DPC_ASSERT_IMP(a_quant_done, q_done, state_reg == dpc_pkg::ST_QUANT,
                    "phase quantizer finished outside its wait state")
    `DPC_ASSERT_NXT(a_busy_after_accept, s_accept, state_reg != dpc_pkg::ST_IDLE,
                    "sequencer idle right after an input beat")

endmodule

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int NUM_PHASES   = 10;
    localparam int DRAIN_CYCLES = 100;
    localparam int TAP_COUNT    = dpc_pkg::TAPS_DEF;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [dpc_pkg::CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [dpc_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [dpc_pkg::CFG_IDX_W-1:0] WORD_REGS [4] = '{
        dpc_pkg::REG_REF_WORD_0, dpc_pkg::REG_REF_WORD_1,
        dpc_pkg::REG_REF_WORD_2, dpc_pkg::REG_REF_WORD_3
    };

    // sin(k * 2pi / 256) scaled to 16384, k = 0..64.
    localparam int unit_sine [65] = '{
        0, 402, 804, 1205, 1606, 2006, 2404, 2801,
        3196, 3590, 3981, 4370, 4756, 5139, 5520, 5897,
        6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765,
        9102, 9434, 9760, 10080, 10394, 10702, 11003, 11297,
        11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
        13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978,
        15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
        16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379,
        16384
    };

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_e;

    typedef struct packed {
        row_kind_e                     kind;
        logic [dpc_pkg::CFG_IDX_W-1:0] idx;
        logic [63:0]                   data;
        logic [15:0]                   si;
        logic [15:0]                   sq;
        logic                          typed;
        logic [19:0]                   mag;
    } dir_row_t;

    localparam int DIR_ROWS = 29;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Zero samples right after reset: phase 0, every filled tap adds 16384.
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h0000, 16'h0000, 1'b1, 20'd16384},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h0000, 16'h0000, 1'b1, 20'd32768},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h7FFF, 16'h0000, 1'b1, 20'd49152},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h8000, 16'h0000, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h0000, 16'h7FFF, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h0000, 16'h8000, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h8000, 16'h8000, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h7FFF, 16'h7FFF, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'hFFFF, 16'h0001, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h0001, 16'hFFFF, 1'b0, 20'd0},
        // With no taps in use the sum is empty.
        '{ROW_WRITE,  dpc_pkg::REG_TAPS_IN_USE, 64'd0, 16'h0000, 16'h0000, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h3039, 16'hEAC8, 1'b1, 20'd0},
        '{ROW_WRITE,  dpc_pkg::REG_TAPS_IN_USE, 64'd63, 16'h0000, 16'h0000, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h8000, 16'h7FFF, 1'b0, 20'd0},
        '{ROW_WRITE,  dpc_pkg::REG_REF_WORD_0, '1, 16'h0000, 16'h0000, 1'b0, 20'd0},
        '{ROW_WRITE,  dpc_pkg::REG_REF_WORD_1, '1, 16'h0000, 16'h0000, 1'b0, 20'd0},
        '{ROW_WRITE,  dpc_pkg::REG_REF_WORD_2, '1, 16'h0000, 16'h0000, 1'b0, 20'd0},
        '{ROW_WRITE,  dpc_pkg::REG_REF_WORD_3, '1, 16'h0000, 16'h0000, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h0064, 16'hFF9C, 1'b0, 20'd0},
        '{ROW_WRITE,  dpc_pkg::REG_TAPS_IN_USE, 64'd1, 16'h0000, 16'h0000, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'hFFF9, 16'h0003, 1'b0, 20'd0},
        '{ROW_WRITE,  dpc_pkg::REG_TAPS_IN_USE, 64'd33, 16'h0000, 16'h0000, 1'b0, 20'd0},
        '{ROW_WRITE,  REG_SPARE_5, '1, 16'h0000, 16'h0000, 1'b0, 20'd0},
        '{ROW_WRITE,  REG_SPARE_7, 64'd0, 16'h0000, 16'h0000, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h7FFF, 16'h8000, 1'b0, 20'd0},
        '{ROW_WRITE,  dpc_pkg::REG_REF_WORD_0, 64'h0123456789ABCDEF, 16'h0000, 16'h0000,
          1'b0, 20'd0},
        '{ROW_WRITE,  dpc_pkg::REG_TAPS_IN_USE, 64'd32, 16'h0000, 16'h0000, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h1234, 16'h5678, 1'b0, 20'd0},
        '{ROW_SAMPLE, dpc_pkg::REG_REF_WORD_0, 64'd0, 16'h0000, 16'h0000, 1'b0, 20'd0}
    };

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [15:0] sample_i, [31:16] sample_q
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // [19:0] corr_magnitude, [23:20] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    differential_phase_correlator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the block: registers and delay line as the predictor sees them.
    logic [63:0] ref_word_model [4];
    logic [5:0]  taps_model;
    logic [7:0]  last_phase;
    logic [7:0]  step_line   [TAP_COUNT];
    bit          step_filled [TAP_COUNT];

    logic [19:0] expected_mag_q [$];

    int samples_sent  = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int fail_count    = 0;
    int burst_left    = 0;
    int cycle_count   = 0;
    int stall_run     = 0;
    bit ready_level   = 1'b1;

    function automatic int phasor_sin(input logic [7:0] k);
        case (k[7:6])
            2'd0:    return unit_sine[k[5:0]];
            2'd1:    return unit_sine[64 - k[5:0]];
            2'd2:    return -unit_sine[k[5:0]];
            default: return -unit_sine[64 - k[5:0]];
        endcase
    endfunction

    function automatic int phasor_cos(input logic [7:0] k);
        return phasor_sin(k + 8'd64);
    endfunction

    // Fold into the first octant, count the step boundaries passed, unfold.
    function automatic logic [7:0] quantize_angle(input logic signed [15:0] si,
                                                  input logic signed [15:0] sq);
        longint x, y, t, c, s;
        bit     swapped;
        bit     passing;
        int     n, a;
        x = (si < 0) ? -longint'(si) : longint'(si);
        y = (sq < 0) ? -longint'(sq) : longint'(sq);
        if (x == 0 && y == 0) return 8'd0;
        swapped = (y > x);
        if (swapped) begin
            t = x;
            x = y;
            y = t;
        end
        n = 0;
        passing = 1'b1;
        for (int j = 0; j < 32 && passing; j++) begin
            c = unit_sine[64 - j] + unit_sine[63 - j];
            s = unit_sine[j] + unit_sine[j + 1];
            if (y * c >= x * s) n++;
            else passing = 1'b0;
        end
        a = swapped ? 64 - n : n;
        if (si < 0) a = 128 - a;
        if (sq < 0) a = 256 - a;
        return 8'(a & 255);
    endfunction

    function automatic logic [7:0] tap_reference(input int k);
        return ref_word_model[(k >> 3) & 3][8 * (k & 7) +: 8];
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Shifts one sample into the shadow delay line and returns its magnitude.
    function automatic logic [19:0] correlate_sample(input logic [15:0] si,
                                                     input logic [15:0] sq);
        logic [7:0]      ph, ang;
        int              n;
        longint          re, im;
        longint unsigned mag;
        ph = quantize_angle(si, sq);
        n = (taps_model > TAP_COUNT) ? TAP_COUNT : int'(taps_model);
        for (int i = TAP_COUNT - 1; i > 0; i--) begin
            step_line[i]   = step_line[i - 1];
            step_filled[i] = step_filled[i - 1];
        end
        step_line[0]   = ph - last_phase;
        step_filled[0] = 1'b1;
        last_phase     = ph;
        re = 0;
        im = 0;
        for (int i = 0; i < n; i++) begin
            if (step_filled[i]) begin
                ang = step_line[i] + tap_reference(n - 1 - i);
                re += phasor_cos(ang);
                im += phasor_sin(ang);
            end
        end
        mag = isqrt64(longint'(re * re + im * im));
        if (mag > dpc_pkg::MAG_LIMIT) mag = dpc_pkg::MAG_LIMIT;
        return mag[19:0];
    endfunction

    function automatic logic [31:0] sample_at(input logic [7:0] ang, input int amp);
        int si, sq;
        si = amp * phasor_cos(ang) / 16384;
        sq = amp * phasor_sin(ang) / 16384;
        return {sq[15:0], si[15:0]};
    endfunction

    task automatic push_sample(input logic [31:0] beat, input bit typed,
                               input logic [19:0] typed_mag);
        logic [19:0] predicted;
        int          gap;
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
        predicted = correlate_sample(beat[15:0], beat[31:16]);
        expected_mag_q.push_back(typed ? typed_mag : predicted);
        samples_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 90);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [dpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            dpc_pkg::REG_REF_WORD_0:  ref_word_model[0] = data;
            dpc_pkg::REG_REF_WORD_1:  ref_word_model[1] = data;
            dpc_pkg::REG_REF_WORD_2:  ref_word_model[2] = data;
            dpc_pkg::REG_REF_WORD_3:  ref_word_model[3] = data;
            dpc_pkg::REG_TAPS_IN_USE: taps_model = data[5:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Registers change only once every sample in flight has produced its beat.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (expected_mag_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Timeout after %0d cycles, %0d results still outstanding",
                 CYCLE_LIMIT, expected_mag_q.size());
        $display("Test completed with failures");
        $finish;
    end

    // Result side: checks every accepted beat and drives its own stall pattern.
    always @(posedge aclk) begin
        logic [19:0] want;
        cycle_count++;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_mag_q.size() == 0) begin
                fail_count++;
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: corr_magnitude %0d", m_tdata[19:0]);
            end else begin
                want = expected_mag_q.pop_front();
                if (m_tdata[19:0] !== want) begin
                    fail_count++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d: corr_magnitude expected %0d, got %0d",
                                 results_seen, want, m_tdata[19:0]);
                end
            end
        end
        case (cycle_count[12:11])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= ($urandom_range(0, 7) == 0);
            default: begin
                if (stall_run == 0) begin
                    ready_level = !ready_level;
                    stall_run   = $urandom_range(1, 60);
                end else begin
                    stall_run--;
                end
                m_tready <= ready_level;
            end
        endcase
    end

    initial begin
        int          kind, len, amp, n_eff, phase_end;
        logic [7:0]  ang;
        logic [5:0]  taps_val;
        logic [63:0] word_val;
        int          tiny_i, tiny_q;

        for (int w = 0; w < 4; w++) ref_word_model[w] = '0;
        taps_model = 6'd32;
        last_phase = '0;
        for (int i = 0; i < TAP_COUNT; i++) begin
            step_line[i]   = '0;
            step_filled[i] = 1'b0;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_WRITE) begin
                drain_pipeline();
                write_reg(DIRECTED[r].idx, DIRECTED[r].data);
            end else begin
                push_sample({DIRECTED[r].sq, DIRECTED[r].si}, DIRECTED[r].typed,
                            DIRECTED[r].mag);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_pipeline();
            for (int w = 0; w < 4; w++) begin
                if (ph == 0)      word_val = '0;
                else if (ph == 1) word_val = '1;
                else              word_val = {$urandom, $urandom};
                write_reg(WORD_REGS[w], word_val);
            end
            case (ph % 6)
                0:       taps_val = 6'd32;
                1:       taps_val = 6'd1;
                2:       taps_val = 6'd2;
                3:       taps_val = 6'($urandom_range(33, 63));
                4:       taps_val = 6'd0;
                default: taps_val = 6'($urandom_range(3, 31));
            endcase
            write_reg(dpc_pkg::REG_TAPS_IN_USE, taps_val);
            if ($urandom_range(0, 2) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_5 : REG_SPARE_7,
                          {$urandom, $urandom});

            n_eff = (taps_model > TAP_COUNT) ? TAP_COUNT : int'(taps_model);
            if (n_eff == 0) n_eff = 8;
            phase_end = samples_sent + RANDOM_ITEMS / NUM_PHASES;
            while (samples_sent < phase_end) begin
                kind = $urandom_range(0, 9);
                if (kind <= 4) begin
                    // A preamble whose phase steps cancel the reference steps,
                    // cut short now and then and with the odd disturbed step.
                    len = (kind == 4) ? $urandom_range(1, n_eff)
                                      : n_eff + $urandom_range(0, 3);
                    ang = 8'($urandom);
                    push_sample(sample_at(ang, $urandom_range(64, 32767)), 1'b0, '0);
                    for (int t = 0; t < len; t++) begin
                        ang = ang - tap_reference(t % n_eff);
                        if ($urandom_range(0, 7) == 0) ang = ang + 8'($urandom_range(0, 4)) - 8'd2;
                        push_sample(sample_at(ang, $urandom_range(256, 32767)), 1'b0, '0);
                    end
                end else if (kind <= 6) begin
                    len = $urandom_range(1, 40);
                    ang = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3) * 64)
                                                      : 8'($urandom);
                    amp = $urandom_range(1, 32767);
                    for (int t = 0; t < len; t++)
                        push_sample(sample_at(ang, amp), 1'b0, '0);
                end else if (kind <= 8) begin
                    len = $urandom_range(1, 20);
                    for (int t = 0; t < len; t++)
                        push_sample(32'($urandom), 1'b0, '0);
                end else begin
                    // Values near zero, the zero sample among them.
                    len = $urandom_range(1, 10);
                    for (int t = 0; t < len; t++) begin
                        tiny_i = $urandom_range(0, 4) - 2;
                        tiny_q = $urandom_range(0, 4) - 2;
                        push_sample({tiny_q[15:0], tiny_i[15:0]}, 1'b0, '0);
                    end
                end
            end
        end

        s_tvalid <= 1'b0;
        while (expected_mag_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d directed rows and %0d setting phases: %0d samples sent",
                 DIR_ROWS, NUM_PHASES, samples_sent);
        $display("%0d result beats checked, %0d failures", results_seen, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
